// File: rtl/core/mkps_pkg.sv
// shared types, constants and helpers of the morse key press segmenter
`default_nettype none
package mkps_pkg;

  localparam int MAX_SIGNALS = 5;
  localparam int TICK_WIDTH  = 16;
  localparam int DUR_W       = 16;
  localparam int POS_W       = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int EXT_W       = TICK_WIDTH + DUR_W;
  localparam int CNT_W       = $clog2(MAX_SIGNALS + 1);
  localparam int IDX_W       = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 1'd1;

  localparam logic [CFG_W-1:0] MIN_PRESS_RESET  = 16'd30;
  localparam logic [CFG_W-1:0] LETTER_GAP_RESET = 16'd400;

  typedef logic [TICK_WIDTH-1:0] tick_t;
  typedef tick_t [MAX_SIGNALS-1:0] store_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    store_t           store;
  } letter_t;

  function automatic tick_t sat_inc(input tick_t v);
    return (v == '1) ? v : v + TICK_WIDTH'(1);
  endfunction

  function automatic logic [EXT_W-1:0] ext_tick(input tick_t v);
    return EXT_W'(v);
  endfunction

  function automatic logic [EXT_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
    return EXT_W'(v);
  endfunction

  function automatic logic [DUR_W-1:0] sat_dur(input tick_t v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > EXT_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : e[DUR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mkps_if.sv
// key sample and press result channel interfaces
`default_nettype none
interface mkps_key_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

interface mkps_press_if import mkps_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] press_ticks;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, output press_ticks, output position, output last,
                  input ready);
  modport sink (input valid, input press_ticks, input position, input last,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/mkps_tracker.sv
// per tick key tracking, press store, letter end detection and config registers
`default_nettype none
module mkps_tracker import mkps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 key_down,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output letter_t                   letter
);

  logic [CFG_W-1:0] min_press;
  logic [CFG_W-1:0] letter_gap;
  logic             key_held;
  logic             key_held_next;
  tick_t            press_counter;
  tick_t            press_counter_next;
  tick_t            gap_counter;
  tick_t            gap_counter_next;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;
  store_t           press_store;
  tick_t            dur;
  logic             accepted;
  logic             store_we;
  logic             letter_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_press  <= MIN_PRESS_RESET;
      letter_gap <= LETTER_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PRESS:  min_press  <= cfg_data;
        CFG_LETTER_GAP: letter_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dur                = sat_inc(press_counter);
    key_held_next      = key_held;
    press_counter_next = press_counter;
    accepted           = 1'b0;
    if (key_down && !key_held) begin
      key_held_next      = 1'b1;
      press_counter_next = '0;
    end else if (key_down && key_held) begin
      press_counter_next = dur;
    end else if (!key_down && key_held) begin
      key_held_next = 1'b0;
      accepted      = ext_tick(dur) >= ext_cfg(min_press);
    end
    store_we          = accepted && (stored_count < CNT_W'(MAX_SIGNALS));
    gap_counter_next  = accepted ? '0 : sat_inc(gap_counter);
    stored_count_next = store_we ? stored_count + CNT_W'(1) : stored_count;
    letter_end        = !key_held_next && (stored_count_next != '0) &&
                        (ext_tick(gap_counter_next) > ext_cfg(letter_gap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_held      <= 1'b0;
      press_counter <= '0;
      gap_counter   <= '0;
      stored_count  <= '0;
    end else if (accept) begin
      key_held      <= key_held_next;
      press_counter <= press_counter_next;
      gap_counter   <= gap_counter_next;
      stored_count  <= letter_end ? '0 : stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      press_store[stored_count[IDX_W-1:0]] <= dur;
    end
  end

  always_comb begin
    letter.valid = accept && letter_end;
    letter.count = stored_count_next;
    letter.store = press_store;
  end

endmodule
`default_nettype wire

// File: rtl/core/mkps_drain.sv
// letter buffer that sends stored presses out one beat at a time
`default_nettype none
module mkps_drain import mkps_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire letter_t letter,
  output logic         free,
  mkps_press_if.source press
);

  store_t           buf_store;
  logic [CNT_W-1:0] buf_len;
  logic [CNT_W-1:0] buf_idx;
  logic             busy;
  logic             beat;
  logic             final_beat;

  always_comb begin
    busy       = buf_idx != buf_len;
    final_beat = (buf_idx + CNT_W'(1)) == buf_len;
    beat       = busy && press.ready;
    free       = !busy || (beat && final_beat);

    press.valid       = busy;
    press.press_ticks = sat_dur(buf_store[buf_idx[IDX_W-1:0]]);
    press.position    = POS_W'(buf_idx);
    press.last        = final_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= '0;
      buf_idx <= '0;
    end else if (letter.valid) begin
      buf_len <= letter.count;
      buf_idx <= '0;
    end else if (beat) begin
      buf_idx <= buf_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (letter.valid) begin
      buf_store <= letter.store;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/morse_key_press_segmenter.sv
// top level of the morse key press segmenter
// usage:
//   key: one beat per millisecond tick carrying the key level (1 pressed)
//   press: one beat per stored press of a finished letter, in press order,
//     with its duration in ticks, its position in the letter and last set on
//     the final press
//   cfg_we/cfg_index/cfg_data: index 0 minimum press ticks, index 1 letter gap
//     ticks; write only while the block is idle
// latency: a tick that ends a letter shows its first press beat on the next
//   cycle; the other presses follow one per cycle while press.ready is high
// throughput: one tick per cycle while no letter drains; a letter keeps the output
//   busy and holds key not ready until its final press beat is taken
// reset: config returns to 30 and 400, key state and counters clear, the
//   press store and letter buffer empty
// stall: when press.ready is low the current beat holds and key stays not
//   ready until the final press beat of the letter is taken
`default_nettype none
module morse_key_press_segmenter import mkps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mkps_key_if.sink                  key,
  mkps_press_if.source              press,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  letter_t letter;
  logic    free;
  logic    accept;

  assign key.ready = free;
  assign accept    = key.valid && free;

  mkps_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .key_down  (key.key_down),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .letter    (letter)
  );

  mkps_drain u_drain (
    .clk    (clk),
    .rst    (rst),
    .letter (letter),
    .free   (free),
    .press  (press)
  );

`ifndef SYNTHESIS
  a_letter_nonempty: assert property (@(posedge clk) disable iff (rst)
    letter.valid |-> (letter.count != '0))
    else $error("letter end with empty store");

  a_letter_only_when_free: assert property (@(posedge clk) disable iff (rst)
    letter.valid |-> (!press.valid || (press.ready && press.last)))
    else $error("letter loaded over undrained presses");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (press.valid && press.ready && press.last && !letter.valid) |=> !press.valid)
    else $error("press beat after final press of letter");

  a_first_position: assert property (@(posedge clk) disable iff (rst)
    letter.valid |=> (press.valid && press.position == '0))
    else $error("letter does not start at position zero");
`endif

endmodule
`default_nettype wire

// File: test/mkps_letter_check.sv
// press beat checker: predicts letter runs from key ticks and compares each press beat
`default_nettype none
module mkps_letter_check import mkps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mkps_key_if                       key,
  mkps_press_if                     press,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fails,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DUR_W-1:0] ticks;
    logic [POS_W-1:0] pos;
    logic             last;
  } press_beat_t;

  press_beat_t      letter_q[$];
  logic [CFG_W-1:0] min_ticks;
  logic [CFG_W-1:0] gap_limit;
  logic             held;
  tick_t            hold_cnt;
  tick_t            up_cnt;
  int               n_stored;
  tick_t            durs[MAX_SIGNALS];

  function automatic tick_t bump(input tick_t v);
    return (v == '1) ? v : v + tick_t'(1);
  endfunction

  task automatic predict_tick(input logic down);
    logic        taken;
    tick_t       d;
    press_beat_t b;
    taken = 1'b0;
    if (down && !held) begin
      held = 1'b1;
      hold_cnt = '0;
    end else if (down) begin
      hold_cnt = bump(hold_cnt);
    end else if (held) begin
      d = bump(hold_cnt);
      held = 1'b0;
      if (d >= min_ticks) begin
        taken = 1'b1;
        if (n_stored < MAX_SIGNALS) begin
          durs[n_stored] = d;
          n_stored++;
        end
      end
    end
    up_cnt = taken ? '0 : bump(up_cnt);
    if (!held && n_stored > 0 && up_cnt > gap_limit) begin
      for (int i = 0; i < n_stored; i++) begin
        b.ticks = DUR_W'(durs[i]);
        b.pos = POS_W'(i);
        b.last = (i == n_stored - 1);
        letter_q = {letter_q, b};
      end
      n_stored = 0;
    end
  endtask

  task automatic check_beat();
    press_beat_t want;
    press_beat_t got;
    got.ticks = press.press_ticks;
    got.pos = press.position;
    got.last = press.last;
    if (letter_q.size() == 0) begin
      if (fails < 10)
        $display("unexpected press beat ticks=%0d pos=%0d last=%0b",
                 got.ticks, got.pos, got.last);
      fails++;
    end else begin
      want = letter_q.pop_front();
      if (got !== want) begin
        if (fails < 10)
          $display("press beat mismatch: expected ticks=%0d pos=%0d last=%0b,",
                   want.ticks, want.pos, want.last,
                   " got ticks=%0d pos=%0d last=%0b",
                   got.ticks, got.pos, got.last);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      letter_q.delete();
      min_ticks = MIN_PRESS_RESET;
      gap_limit = LETTER_GAP_RESET;
      held = 1'b0;
      hold_cnt = '0;
      up_cnt = '0;
      n_stored = 0;
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PRESS: min_ticks = cfg_data;
          CFG_LETTER_GAP: gap_limit = cfg_data;
          default: ;
        endcase
      end
      if (key.valid && key.ready) predict_tick(key.key_down);
      if (press.valid && press.ready) check_beat();
    end
    pending = letter_q.size();
  end
endmodule
`default_nettype wire

// File: test/tb_morse_key_press_segmenter.sv
// testbench top: key tick stimulus, config writes, press stalls and verdict
`default_nettype none
module tb_morse_key_press_segmenter import mkps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fails;
  int pending;
  int quiet;
  int ticks_sent = 0;
  int hold_len = 0;
  int cur_min = 30;
  int cur_gap = 400;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  mkps_key_if   key_ch();
  mkps_press_if press_ch();

  morse_key_press_segmenter dut (
    .clk       (clk),
    .rst       (rst),
    .key       (key_ch),
    .press     (press_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mkps_letter_check letter_check (
    .clk       (clk),
    .rst       (rst),
    .key       (key_ch),
    .press     (press_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (press_ch.valid && press_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb_morse_key_press_segmenter failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // press channel backpressure
  initial begin
    press_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        press_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        press_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        press_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic down);
    key_ch.valid <= 1'b1;
    key_ch.key_down <= down;
    do @(posedge clk); while (!key_ch.ready);
    ticks_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // len ticks down, then up ticks starting with the release tick
  task automatic press_key(input int len, input int up);
    repeat (len) send_tick(1'b1);
    repeat (up) send_tick(1'b0);
  endtask

  task automatic settle();
    key_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int min_t, input int gap_t);
    write_reg(CFG_MIN_PRESS, CFG_W'(min_t));
    write_reg(CFG_LETTER_GAP, CFG_W'(gap_t));
    cur_min = min_t;
    cur_gap = gap_t;
  endtask

  task automatic random_letter();
    int presses;
    int up;
    presses = $urandom_range(1, MAX_SIGNALS + 2);
    for (int i = 0; i < presses; i++) begin
      if (i == presses - 1) up = $urandom_range(cur_gap + 2, cur_gap + 4);
      else if ($urandom_range(0, 7) == 0) up = cur_gap + 2;
      else up = $urandom_range(1, cur_gap + 1);
      press_key($urandom_range(1, cur_min + 3), up);
    end
  endtask

  initial begin
    int round;
    key_ch.valid <= 1'b0;
    key_ch.key_down <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MIN_PRESS;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timing: press at the minimum, then a short one that is dropped
    press_key(30, 1);
    press_key(29, 2);

    // maximum minimum drops a short press
    write_reg(CFG_MIN_PRESS, 16'hffff);
    press_key(3, 2);

    // zero minimum and zero gap
    set_timing(0, 0);
    press_key(1, 1);
    press_key(1, 2);
    press_key(1, 2);

    // store full, then a dropped press inside the gap
    set_timing(2, 3);
    repeat (6) press_key(2, 2);
    press_key(1, 2);
    press_key(3, 6);

    // long press stall while one-press letters keep coming
    set_timing(0, 0);
    gaps_on = 1'b0;
    hold_len = 80;
    repeat (10) press_key(1, 2);
    settle();
    gaps_on = 1'b1;

    round = 0;
    while (ticks_sent < 165) begin
      if (round % 4 == 0) set_timing($urandom_range(0, 4), $urandom_range(0, 6));
      if ($urandom_range(0, 4) != 0) begin
        random_letter();
      end else begin
        repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
      end
      round++;
    end

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_timing(2, 3);
    repeat (2) random_letter();

    settle();
    if (fails == 0 && pending == 0) begin
      $display("tb_morse_key_press_segmenter passed");
    end else begin
      $display("tb_morse_key_press_segmenter failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/mkps_pkg.sv
rtl/core/mkps_if.sv
rtl/core/mkps_tracker.sv
rtl/core/mkps_drain.sv
rtl/core/morse_key_press_segmenter.sv
test/mkps_letter_check.sv
test/tb_morse_key_press_segmenter.sv
